>>> hdl/ranking_marginal_histogram_macros.svh
// Assertion macros shared by the ranking marginal histogram RTL.
`ifndef RANKING_MARGINAL_HISTOGRAM_MACROS_SVH
`define RANKING_MARGINAL_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMH_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked later than the antecedent.
`define RMH_ASSERT_AFTER2(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

>>> hdl/rmh_pkg.sv
// Shared constants, command codes and transaction types of the ranking marginal histogram.
package rmh_pkg;

	localparam int MAX_ITEMS  = 8;
	localparam int COUNT_BITS = 16;
	localparam int OUT_BITS   = 16;
	localparam int CFG_W      = 4;
	localparam int ITEM_W     = $clog2(MAX_ITEMS);
	localparam int N_W        = $clog2(MAX_ITEMS + 1);
	localparam int POS_AW     = 2 * ITEM_W;
	localparam int PAIR_AW    = 4 * ITEM_W;
	localparam int POS_DEPTH  = MAX_ITEMS * MAX_ITEMS;
	localparam int PAIR_DEPTH = POS_DEPTH * POS_DEPTH;
	localparam logic [CFG_W-1:0] ITEMS_RESET = CFG_W'(8);

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RD_POS  = 2'd1,
		CMD_RD_PAIR = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ITEM_W-1:0] item_a;
		logic [ITEM_W-1:0] item_b;
		logic [ITEM_W-1:0] pos_a;
		logic [ITEM_W-1:0] pos_b;
	} req_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] count;
		logic [OUT_BITS-1:0] rankings_seen;
		logic                query_error;
	} rsp_t;

endpackage

>>> hdl/rmh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rmh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/ranking_marginal_histogram.sv
// Ranking marginal histogram: loads rankings one item id per transaction and keeps saturating
// per-item position counts and per-pair joint position counts in two synchronous RAMs. A load
// that does not complete a ranking leaves the block idle. A query holds off the next transaction
// while its result is formed: the count RAM read data is registered, then the result register
// takes it and raises rsp_valid. A result held by rsp_stall blocks every new transaction until
// it is taken. The load that completes a ranking starts a read-modify-write walk over the count
// RAMs, one update per cycle: n position updates plus n*(n-1)/2 pair updates and a final
// write-back, during which no transaction is taken. After reset and after every clear command,
// a sweep zeroes both count RAMs, one pair RAM entry a cycle over all 4096 pair RAM entries,
// before the next transaction is taken; configuration writes are taken at any time.
`include "ranking_marginal_histogram_macros.svh"

module ranking_marginal_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rmh_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  rmh_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output rmh_pkg::rsp_t                 rsp
);

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_WALK,
		ST_QUERY
	} state_t;

	localparam int CW  = rmh_pkg::COUNT_BITS;
	localparam int IW  = rmh_pkg::ITEM_W;
	localparam int NW  = rmh_pkg::N_W;

	// saturating increment of a stored count
	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == {CW{1'b1}}) ? v : v + CW'(1);
	endfunction

	// clip a stored count to the output width
	function automatic logic [rmh_pkg::OUT_BITS-1:0] clip(input logic [CW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		if (w > 64'((64'd1 << rmh_pkg::OUT_BITS) - 64'd1)) begin
			return {rmh_pkg::OUT_BITS{1'b1}};
		end
		return rmh_pkg::OUT_BITS'(w);
	endfunction

	state_t                       state_q;
	logic [rmh_pkg::PAIR_AW-1:0]  clr_cnt_q;
	logic [rmh_pkg::CFG_W-1:0]    items_q;
	logic [IW-1:0]                pos_cnt_q;
	logic [CW-1:0]                total_q;
	logic [IW-1:0]                i_q;
	logic [IW-1:0]                j_q;
	logic [IW-1:0]                pi_q;
	logic [IW-1:0]                rank_buf_q [rmh_pkg::MAX_ITEMS];
	logic                         qry_pair_q;
	logic                         qry_err_q;
	rmh_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;

	logic                         wb_valid_s1;
	logic                         wb_pair_s1;
	logic [rmh_pkg::POS_AW-1:0]   wb_pos_addr_s1;
	logic [rmh_pkg::PAIR_AW-1:0]  wb_pair_addr_s1;

	logic [NW-1:0]                n_eff;
	logic [NW-1:0]                n_last;
	logic                         accept;
	logic                         walking;
	logic                         walk_pos;
	logic [IW-1:0]                rb_rd;
	logic [NW-1:0]                pos_next;
	logic                         err_pos;
	logic                         err_pair;

	logic                         pos_we;
	logic [rmh_pkg::POS_AW-1:0]   pos_waddr;
	logic [CW-1:0]                pos_wdata;
	logic [rmh_pkg::POS_AW-1:0]   pos_raddr;
	logic [CW-1:0]                pos_rdata;
	logic                         pair_we;
	logic [rmh_pkg::PAIR_AW-1:0]  pair_waddr;
	logic [CW-1:0]                pair_wdata;
	logic [rmh_pkg::PAIR_AW-1:0]  pair_raddr;
	logic [CW-1:0]                pair_rdata;
	logic [CW-1:0]                qry_cnt;

	logic                         qry_acc;
	logic                         err_rsp;

	// effective item count, clamped to 2..MAX_ITEMS
	always_comb begin
		if (int'(items_q) < 2) begin
			n_eff = NW'(2);
		end else if (int'(items_q) > rmh_pkg::MAX_ITEMS) begin
			n_eff = NW'(rmh_pkg::MAX_ITEMS);
		end else begin
			n_eff = NW'(items_q);
		end
	end
	assign n_last = n_eff - NW'(1);

	// handshake
	assign req_stall = (state_q != ST_IDLE) || wb_valid_s1 || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// walk addressing: diagonal step is the position update of item i
	assign walking  = (state_q == ST_WALK);
	assign walk_pos = (i_q == j_q);
	assign rb_rd    = rank_buf_q[j_q];
	assign pos_next = NW'(pos_cnt_q) + NW'(1);

	// query range checks
	assign err_pos  = (NW'(req.item_a) >= n_eff) || (NW'(req.pos_a) >= n_eff);
	assign err_pair = (req.item_a >= req.item_b) || (NW'(req.item_b) >= n_eff)
		|| (NW'(req.pos_a) >= n_eff) || (NW'(req.pos_b) >= n_eff);

	// read addresses: walk or incoming query
	always_comb begin
		if (walking) begin
			pos_raddr  = {i_q, rb_rd};
			pair_raddr = {i_q, j_q, pi_q, rb_rd};
		end else begin
			pos_raddr  = {req.item_a, req.pos_a};
			pair_raddr = {req.item_a, req.item_b, req.pos_a, req.pos_b};
		end
	end

	// write side: clearing sweep or write-back of the walk
	always_comb begin
		if (state_q == ST_CLR) begin
			pos_we     = 1'b1;
			pos_waddr  = clr_cnt_q[rmh_pkg::POS_AW-1:0];
			pos_wdata  = '0;
			pair_we    = 1'b1;
			pair_waddr = clr_cnt_q;
			pair_wdata = '0;
		end else begin
			pos_we     = wb_valid_s1 && !wb_pair_s1;
			pos_waddr  = wb_pos_addr_s1;
			pos_wdata  = sat_inc(pos_rdata);
			pair_we    = wb_valid_s1 && wb_pair_s1;
			pair_waddr = wb_pair_addr_s1;
			pair_wdata = sat_inc(pair_rdata);
		end
	end

	rmh_ram #(
		.WIDTH(CW),
		.DEPTH(rmh_pkg::POS_DEPTH)
	) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	rmh_ram #(
		.WIDTH(CW),
		.DEPTH(rmh_pkg::PAIR_DEPTH)
	) u_pair_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.raddr (pair_raddr),
		.rdata (pair_rdata)
	);

	assign qry_cnt = qry_err_q ? '0 : (qry_pair_q ? pair_rdata : pos_rdata);

	// rank buffer: position of each loaded item id
	always_ff @(posedge clk) begin
		if (accept && req.cmd == rmh_pkg::CMD_LOAD && NW'(req.item_a) < n_eff) begin
			rank_buf_q[req.item_a] <= pos_cnt_q;
		end
	end

	// write-back stage of the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_s1     <= 1'b0;
			wb_pair_s1      <= 1'b0;
			wb_pos_addr_s1  <= '0;
			wb_pair_addr_s1 <= '0;
		end else begin
			wb_valid_s1     <= walking;
			wb_pair_s1      <= !walk_pos;
			wb_pos_addr_s1  <= pos_raddr;
			wb_pair_addr_s1 <= pair_raddr;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= rmh_pkg::ITEMS_RESET;
		end else if (cfg_wr_en) begin
			items_q <= cfg_wr_data;
		end
	end

	// control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			pos_cnt_q   <= '0;
			total_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			pi_q        <= '0;
			qry_pair_q  <= 1'b0;
			qry_err_q   <= 1'b0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + rmh_pkg::PAIR_AW'(1);
					if (clr_cnt_q == {rmh_pkg::PAIR_AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							rmh_pkg::CMD_LOAD: begin
								if (pos_next >= n_eff) begin
									pos_cnt_q <= '0;
									total_q   <= sat_inc(total_q);
									i_q       <= '0;
									j_q       <= '0;
									state_q   <= ST_WALK;
								end else begin
									pos_cnt_q <= pos_cnt_q + IW'(1);
								end
							end
							rmh_pkg::CMD_RD_POS: begin
								qry_pair_q <= 1'b0;
								qry_err_q  <= err_pos;
								state_q    <= ST_QUERY;
							end
							rmh_pkg::CMD_RD_PAIR: begin
								qry_pair_q <= 1'b1;
								qry_err_q  <= err_pair;
								state_q    <= ST_QUERY;
							end
							rmh_pkg::CMD_CLEAR: begin
								clr_cnt_q <= '0;
								total_q   <= '0;
								pos_cnt_q <= '0;
								state_q   <= ST_CLR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					// capture item i's position on its diagonal step
					if (walk_pos) begin
						pi_q <= rb_rd;
					end
					if (NW'(j_q) == n_last) begin
						if (NW'(i_q) == n_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + IW'(1);
							j_q <= i_q + IW'(1);
						end
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_QUERY: begin
					rsp_q.count         <= clip(qry_cnt);
					rsp_q.rankings_seen <= clip(total_q);
					rsp_q.query_error   <= qry_err_q;
					rsp_valid_q         <= 1'b1;
					state_q             <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// check terms
	assign qry_acc = accept && (req.cmd inside {rmh_pkg::CMD_RD_POS, rmh_pkg::CMD_RD_PAIR});
	assign err_rsp = rsp_valid && rsp.query_error;

	// checks
	`RMH_ASSERT_IMPLY(a_wb_clr, clk, arst_n, wb_valid_s1, state_q != ST_CLR, "wb in sweep")
	`RMH_ASSERT_IMPLY(a_walk_pos, clk, arst_n, walking, pos_cnt_q == '0, "counter not zero")
	`RMH_ASSERT_IMPLY(a_err_cnt, clk, arst_n, err_rsp, rsp.count == '0, "error with count")
	`RMH_ASSERT_AFTER2(a_qry_rsp, clk, arst_n, qry_acc, rsp_valid, "query gave no result")

endmodule

>>> test/tb_ranking_marginal_histogram.sv
// Self-checking testbench for the ranking marginal histogram: random and directed traffic.
module tb_ranking_marginal_histogram;
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the expected position and pair counts and holds the query results still owed
	class MarginalTally;
		int unsigned items_cfg;
		logic [rmh_pkg::ITEM_W-1:0] rank_pos [rmh_pkg::MAX_ITEMS];
		int unsigned next_pos;
		bit [rmh_pkg::COUNT_BITS-1:0] pos_hits [rmh_pkg::MAX_ITEMS][rmh_pkg::MAX_ITEMS];
		bit [rmh_pkg::COUNT_BITS-1:0] pair_hits [rmh_pkg::MAX_ITEMS][rmh_pkg::MAX_ITEMS]
			[rmh_pkg::MAX_ITEMS][rmh_pkg::MAX_ITEMS];
		bit [rmh_pkg::COUNT_BITS-1:0] rankings;
		rmh_pkg::rsp_t pending_counts [$];
		int unsigned mismatches;
		int unsigned accepted;
		int unsigned checked;
		int unsigned completed;

		function new();
			items_cfg = int'(rmh_pkg::ITEMS_RESET);
			for (int i = 0; i < rmh_pkg::MAX_ITEMS; i++)
				rank_pos[i] = '0;
			mismatches = 0;
			accepted = 0;
			checked = 0;
			completed = 0;
			clear_all();
		endfunction

		function void clear_all();
			for (int i = 0; i < rmh_pkg::MAX_ITEMS; i++)
				for (int j = 0; j < rmh_pkg::MAX_ITEMS; j++) begin
					pos_hits[i][j] = '0;
					for (int k = 0; k < rmh_pkg::MAX_ITEMS; k++)
						for (int l = 0; l < rmh_pkg::MAX_ITEMS; l++)
							pair_hits[i][j][k][l] = '0;
				end
			rankings = '0;
			next_pos = 0;
		endfunction

		function void write_items(logic [rmh_pkg::CFG_W-1:0] v);
			items_cfg = int'(v);
		endfunction

		// Out-of-range settings clamp to the legal span
		function int eff_items();
			if (items_cfg < 2)
				return 2;
			if (items_cfg > rmh_pkg::MAX_ITEMS)
				return rmh_pkg::MAX_ITEMS;
			return int'(items_cfg);
		endfunction

		function bit [rmh_pkg::COUNT_BITS-1:0] inc_sat(bit [rmh_pkg::COUNT_BITS-1:0] c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		function logic [rmh_pkg::OUT_BITS-1:0] clip_out(bit [rmh_pkg::COUNT_BITS-1:0] v);
			if (v > {rmh_pkg::OUT_BITS{1'b1}})
				return {rmh_pkg::OUT_BITS{1'b1}};
			return rmh_pkg::OUT_BITS'(v);
		endfunction

		function void complete(int n);
			for (int i = 0; i < n; i++) begin
				pos_hits[i][rank_pos[i]] = inc_sat(pos_hits[i][rank_pos[i]]);
				for (int j = i + 1; j < n; j++)
					pair_hits[i][j][rank_pos[i]][rank_pos[j]] =
						inc_sat(pair_hits[i][j][rank_pos[i]][rank_pos[j]]);
			end
			rankings = inc_sat(rankings);
			completed++;
		endfunction

		// Apply one accepted request transaction
		function void take_request(rmh_pkg::req_t t);
			int n;
			bit err;
			rmh_pkg::rsp_t exp;
			n = eff_items();
			accepted++;
			exp = '0;
			case (t.cmd)
				rmh_pkg::CMD_LOAD: begin
					if (t.item_a < n)
						rank_pos[t.item_a] = rmh_pkg::ITEM_W'(next_pos);
					if (next_pos + 1 >= n) begin
						next_pos = 0;
						complete(n);
					end else begin
						next_pos = next_pos + 1;
					end
				end
				rmh_pkg::CMD_CLEAR: begin
					clear_all();
				end
				rmh_pkg::CMD_RD_POS: begin
					err = (t.item_a >= n) || (t.pos_a >= n);
					exp.count = err ? '0 : clip_out(pos_hits[t.item_a][t.pos_a]);
					exp.rankings_seen = clip_out(rankings);
					exp.query_error = err;
					pending_counts = {pending_counts, exp};
				end
				default: begin
					err = (t.item_a >= t.item_b) || (t.item_b >= n) ||
						(t.pos_a >= n) || (t.pos_b >= n);
					exp.count = err ? '0 :
						clip_out(pair_hits[t.item_a][t.item_b][t.pos_a][t.pos_b]);
					exp.rankings_seen = clip_out(rankings);
					exp.query_error = err;
					pending_counts = {pending_counts, exp};
				end
			endcase
		endfunction

		function void note_failure(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: %s", msg);
		endfunction

		// Compare one response transaction with the oldest owed result
		function void check_count(rmh_pkg::rsp_t got);
			rmh_pkg::rsp_t exp;
			if (pending_counts.size() == 0) begin
				note_failure($sformatf("unexpected result count=%0d rankings_seen=%0d err=%0b",
					got.count, got.rankings_seen, got.query_error));
				return;
			end
			exp = pending_counts.pop_front();
			checked++;
			if (got.count !== exp.count || got.rankings_seen !== exp.rankings_seen ||
			    got.query_error !== exp.query_error)
				note_failure($sformatf({"result %0d: count exp %0d got %0d, ",
					"rankings_seen exp %0d got %0d, query_error exp %0b got %0b"},
					checked, exp.count, got.count, exp.rankings_seen, got.rankings_seen,
					exp.query_error, got.query_error));
		endfunction

		function int outstanding();
			return pending_counts.size();
		endfunction

		function int unsigned final_failures();
			if (pending_counts.size() != 0)
				note_failure($sformatf("%0d results never arrived", pending_counts.size()));
			return mismatches;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [rmh_pkg::CFG_W-1:0] cfg_wr_data;
	logic req_valid;
	logic req_stall;
	rmh_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rmh_pkg::rsp_t rsp;

	MarginalTally tally = new();
	bit req_idle;
	int settings_seen;

	ranking_marginal_histogram DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function rmh_pkg::req_t mk(rmh_pkg::cmd_t c, int a, int b, int pa, int pb);
		rmh_pkg::req_t t;
		t.cmd = c;
		t.item_a = rmh_pkg::ITEM_W'(a);
		t.item_b = rmh_pkg::ITEM_W'(b);
		t.pos_a = rmh_pkg::ITEM_W'(pa);
		t.pos_b = rmh_pkg::ITEM_W'(pb);
		return t;
	endfunction

	function rmh_pkg::req_t rand_req();
		return mk(rmh_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 7),
			$urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
	endfunction

	// Mostly legal queries, often aimed at the positions of the last ranking
	function rmh_pkg::req_t pick_query(int n);
		rmh_pkg::req_t t;
		int a;
		int b;
		t = rand_req();
		t.cmd = $urandom_range(0, 1) ? rmh_pkg::CMD_RD_POS : rmh_pkg::CMD_RD_PAIR;
		if ($urandom_range(0, 3) == 0)
			return t;
		if (t.cmd == rmh_pkg::CMD_RD_POS) begin
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, 7);
		end else begin
			a = $urandom_range(0, n - 2);
			b = $urandom_range(a + 1, n - 1);
		end
		t.item_a = rmh_pkg::ITEM_W'(a);
		t.item_b = rmh_pkg::ITEM_W'(b);
		if ($urandom_range(0, 1)) begin
			t.pos_a = tally.rank_pos[a];
			t.pos_b = tally.rank_pos[b];
		end else begin
			t.pos_a = rmh_pkg::ITEM_W'($urandom_range(0, n - 1));
			t.pos_b = rmh_pkg::ITEM_W'($urandom_range(0, n - 1));
		end
		return t;
	endfunction

	// Drive one request transaction; entered and left at a falling edge
	task send_req(rmh_pkg::req_t t);
		int gap;
		gap = req_idle ? $urandom_range(0, 17) : 0;
		if (gap != 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = t;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tally.take_request(t);
		@(negedge clk);
	endtask

	task drain_results();
		req_valid = 1'b0;
		while (tally.outstanding() != 0)
			@(negedge clk);
	endtask

	// Register write only once the block has gone quiet
	task set_items(logic [rmh_pkg::CFG_W-1:0] v);
		drain_results();
		repeat (64) @(negedge clk);
		while (req_stall)
			@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tally.write_items(v);
		settings_seen++;
	endtask

	task run_phase(logic [rmh_pkg::CFG_W-1:0] setting, int budget);
		int n;
		int sent;
		int r;
		int j;
		int tmp;
		int order [rmh_pkg::MAX_ITEMS];
		rmh_pkg::req_t t;
		set_items(setting);
		sent = 0;
		while (sent < budget) begin
			n = tally.eff_items();
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 15) == 0)
				req_idle = !req_idle;
			if ($urandom_range(0, 63) == 0)
				drain_results();
			if (r < 55) begin
				// Well-formed ranking: a shuffled set of ids, queries mixed in
				for (int k = 0; k < n; k++)
					order[k] = k;
				for (int k = n - 1; k > 0; k--) begin
					j = $urandom_range(0, k);
					tmp = order[k];
					order[k] = order[j];
					order[j] = tmp;
				end
				for (int k = 0; k < n; k++) begin
					t = rand_req();
					t.cmd = rmh_pkg::CMD_LOAD;
					t.item_a = rmh_pkg::ITEM_W'(order[k]);
					send_req(t);
					sent++;
					if ($urandom_range(0, 3) == 0) begin
						send_req(pick_query(n));
						sent++;
					end
				end
			end else if (r < 80) begin
				send_req(pick_query(n));
				sent++;
			end else if (r < 97) begin
				// Stray load, any id
				t = rand_req();
				t.cmd = rmh_pkg::CMD_LOAD;
				send_req(t);
				sent++;
			end else if (r == 97) begin
				t = rand_req();
				t.cmd = rmh_pkg::CMD_CLEAR;
				send_req(t);
				sent++;
			end else begin
				send_req(rand_req());
				sent++;
			end
		end
	endtask

	// Response side: checks results and stalls at random
	initial begin
		int hold;
		bit rsp_idle;
		hold = 0;
		rsp_idle = 1'b1;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				tally.check_count(rsp);
				hold = rsp_idle ? $urandom_range(0, 17) : 0;
				if ($urandom_range(0, 39) == 0)
					rsp_idle = !rsp_idle;
			end else if (hold == 0 && rsp_idle && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 17);
			end
			@(negedge clk);
			if (hold != 0) begin
				rsp_stall = 1'b1;
				hold--;
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	// Stimulus
	initial begin
		int perm8 [rmh_pkg::MAX_ITEMS];
		logic [rmh_pkg::CFG_W-1:0] plan [12];
		int unsigned failures;
		perm8 = '{7, 0, 6, 1, 5, 2, 4, 3};
		plan = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd3, 4'd7, 4'd1, 4'd9, 4'd4, 4'd6, 4'd8};
		settings_seen = 0;
		req_idle = 1'b1;
		req_valid = 1'b0;
		req = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: a full first ranking writes every id before anything reads it
		for (int k = 0; k < rmh_pkg::MAX_ITEMS; k++)
			send_req(mk(rmh_pkg::CMD_LOAD, perm8[k], 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_RD_POS, 7, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_RD_POS, 0, 7, 7, 7));
		send_req(mk(rmh_pkg::CMD_RD_PAIR, 0, 7, 1, 0));
		send_req(mk(rmh_pkg::CMD_RD_PAIR, 3, 3, 0, 0));
		send_req(mk(rmh_pkg::CMD_RD_PAIR, 7, 0, 7, 7));
		send_req(mk(rmh_pkg::CMD_CLEAR, 7, 7, 7, 7));
		send_req(mk(rmh_pkg::CMD_RD_POS, 7, 0, 0, 0));
		// Partial ranking thrown away by a clear
		send_req(mk(rmh_pkg::CMD_LOAD, 2, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_LOAD, 4, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_LOAD, 6, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_CLEAR, 0, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_RD_PAIR, 1, 2, 3, 6));
		// Setting below the minimum; id out of use still takes a position
		set_items(4'd1);
		send_req(mk(rmh_pkg::CMD_LOAD, 5, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_LOAD, 1, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_RD_POS, 2, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_RD_POS, 0, 0, 1, 0));
		send_req(mk(rmh_pkg::CMD_RD_PAIR, 0, 1, 1, 1));

		// Two-item rankings back to back in both orders, then position and pair counts read back
		set_items(4'd2);
		req_idle = 1'b0;
		for (int k = 0; k < 5; k++) begin
			send_req(mk(rmh_pkg::CMD_LOAD, 0, 0, 0, 0));
			send_req(mk(rmh_pkg::CMD_LOAD, 1, 0, 0, 0));
		end
		for (int k = 0; k < 3; k++) begin
			send_req(mk(rmh_pkg::CMD_LOAD, 1, 0, 0, 0));
			send_req(mk(rmh_pkg::CMD_LOAD, 0, 0, 0, 0));
		end
		req_idle = 1'b1;
		send_req(mk(rmh_pkg::CMD_RD_POS, 0, 0, 0, 0));
		send_req(mk(rmh_pkg::CMD_RD_POS, 1, 0, 1, 0));
		send_req(mk(rmh_pkg::CMD_RD_POS, 0, 0, 1, 0));
		send_req(mk(rmh_pkg::CMD_RD_PAIR, 0, 1, 0, 1));
		send_req(mk(rmh_pkg::CMD_RD_PAIR, 0, 1, 1, 0));
		send_req(mk(rmh_pkg::CMD_CLEAR, 0, 0, 0, 0));

		// Random phases over a spread of settings
		foreach (plan[p])
			run_phase(plan[p], 108);

		drain_results();
		repeat (64) @(negedge clk);
		failures = tally.final_failures();
		$display("Covered %0d request transactions, %0d checked results, %0d completed rankings",
			tally.accepted, tally.checked, tally.completed);
		$display("across %0d items-in-use settings, including out-of-range ones",
			settings_seen);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
